// File: src/swude_pkg.sv
// Shared types, codes and the CRC-8 step function of the datagram engine.
// No dependencies; every other source file imports this package.
package swude_pkg;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_RX    = 2'd2;

	localparam logic KIND_TX    = 1'b0;
	localparam logic KIND_REPLY = 1'b1;

	localparam logic [7:0] SYNC_BYTE  = 8'h05;
	localparam logic [7:0] CRC_POLY   = 8'h07;
	localparam logic [7:0] WRITE_FLAG = 8'h80;
	localparam logic [2:0] ECHO_LEN   = 3'd4;
	localparam logic [2:0] REPLY_LAST = 3'd7;
	localparam logic [2:0] WRITE_LAST = 3'd7;
	localparam logic [2:0] READ_LAST  = 3'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [6:0]  reg_addr;
		logic [31:0] write_data;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  tx_byte;
		logic        last;
		logic [31:0] reply_data;
		logic [6:0]  reply_register;
		logic        crc_ok;
	} result_t;

	typedef enum logic [1:0] {
		JOB_WRITE,
		JOB_READ,
		JOB_REPLY
	} job_kind_t;

	// One unit of back-end work: a datagram to send or a finished reply.
	typedef struct packed {
		job_kind_t   kind;
		logic [1:0]  node;
		logic [6:0]  reg_addr;
		logic [31:0] data;
		logic        crc_ok;
	} job_t;

	// Feed one byte, least significant bit first.
	function automatic logic [7:0] crc8_feed(input logic [7:0] crc_in, input logic [7:0] b);
		logic [7:0] c;
		logic       fb;
		c = crc_in;
		for (int k = 0; k < 8; k++) begin
			fb = c[7] ^ b[k];
			c = {c[6:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

endpackage

// File: src/single_wire_uart_datagram_engine_core.sv
// Top level of the single-wire UART datagram engine: front end, job queue, back end.
// Depends on swude_pkg, swude_front, swude_queue and swude_back.
//
// Push an item when full is low; pop result beats while empty is low. A write
// request yields eight transmit beats (sync, node address, register with the
// write bit, four data bytes most significant first, CRC-8), a read request
// yields four (sync, address, register, CRC) and arms the block to drop the
// next four received bytes as echo. Received bytes are gathered by the front
// end; the eighth byte of a reply yields one reply beat carrying data,
// register and a CRC-ok flag. The front end takes one item per cycle while the
// job queue has room. The back end emits one beat per cycle through its output
// register while its output slot is free or being popped, so a write request
// occupies it for eight beats, a read request for four and a reply for one; with
// pop held high the serializer sets the sustained rate. The user must write the
// node address via cfg_we/cfg_data only while the block is idle; it does not check.
module single_wire_uart_datagram_engine_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_data,
	input  logic               push,
	output logic               full,
	input  swude_pkg::item_t   item,
	output logic               empty,
	input  logic               pop,
	output swude_pkg::result_t result
);
	import swude_pkg::*;

	logic accept;
	logic job_push;
	job_t front_job;
	logic job_valid;
	logic job_pop;
	job_t head_job;

	// Hold off every item while the queue is full; results keep their order.
	assign accept = push && !full;

	swude_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.accept   (accept),
		.item     (item),
		.job_push (job_push),
		.job      (front_job)
	);

	swude_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (front_job),
		.full     (full),
		.pop      (job_pop),
		.valid    (job_valid),
		.head     (head_job)
	);

	// Advance through the head job beat by beat; drop it after its last beat.
	swude_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (head_job),
		.job_pop   (job_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

// File: src/swude_front.sv
// Front end: accepts items, tracks reception state and classifies work into jobs.
// Depends on swude_pkg.
module swude_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_data,
	input  logic                accept,
	input  swude_pkg::item_t    item,
	output logic                job_push,
	output swude_pkg::job_t     job
);
	import swude_pkg::*;

	logic [1:0]  node_address_q;
	logic [2:0]  echo_skip_q;
	logic [2:0]  rx_count_q;
	logic [55:0] rx_frame_q;
	logic [7:0]  rx_crc_q;

	logic [7:0]  rx_crc_next;

	assign rx_crc_next = crc8_feed(rx_crc_q, item.rx_byte);

	always_comb begin
		job_push = 1'b0;
		job.kind = JOB_WRITE;
		job.node = node_address_q;
		job.reg_addr = item.reg_addr;
		job.data = item.write_data;
		job.crc_ok = 1'b0;
		unique case (item.op)
			OP_WRITE: begin
				job_push = accept;
			end
			OP_READ: begin
				job_push = accept;
				job.kind = JOB_READ;
			end
			OP_RX: begin
				job_push = accept && (echo_skip_q == 3'd0) && (rx_count_q == REPLY_LAST);
				job.kind = JOB_REPLY;
				job.reg_addr = rx_frame_q[38:32];
				job.data = rx_frame_q[31:0];
				job.crc_ok = (rx_crc_q == item.rx_byte);
			end
			default: begin
				job_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_address_q <= 2'd0;
		end else if (cfg_we) begin
			node_address_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_skip_q <= 3'd0;
			rx_count_q  <= 3'd0;
			rx_frame_q  <= '0;
			rx_crc_q    <= 8'd0;
		end else if (accept) begin
			if (item.op == OP_READ) begin
				echo_skip_q <= ECHO_LEN;
				rx_count_q  <= 3'd0;
				rx_frame_q  <= '0;
				rx_crc_q    <= 8'd0;
			end else if (item.op == OP_RX) begin
				if (echo_skip_q != 3'd0) begin
					echo_skip_q <= echo_skip_q - 3'd1;
				end else if (rx_count_q != REPLY_LAST) begin
					rx_frame_q <= {rx_frame_q[47:0], item.rx_byte};
					rx_crc_q   <= rx_crc_next;
					rx_count_q <= rx_count_q + 3'd1;
				end else begin
					rx_count_q <= 3'd0;
					rx_frame_q <= '0;
					rx_crc_q   <= 8'd0;
				end
			end
		end
	end

endmodule

// File: src/swude_queue.sv
// Short job queue between front and back ends, built from registers.
// Depends on swude_pkg for the job type.
module swude_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  swude_pkg::job_t push_job,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output swude_pkg::job_t head
);
	import swude_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign valid   = (count_q != '0);
	assign head    = slots_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: src/swude_back.sv
// Back end: serializes jobs into result beats, one per cycle unless stalled by pop, with the tx CRC.
// Depends on swude_pkg.
module swude_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  swude_pkg::job_t   job,
	output logic              job_pop,
	output logic              empty,
	input  logic              pop,
	output swude_pkg::result_t result
);
	import swude_pkg::*;

	logic [2:0] idx_q;
	logic [7:0] crc_q;
	logic       out_valid_q;
	result_t    result_q;

	logic [7:0] cur_byte;
	logic       cur_last;
	logic       load;
	result_t    next_res;

	always_comb begin
		cur_byte = SYNC_BYTE;
		cur_last = 1'b0;
		unique case (job.kind)
			JOB_WRITE: begin
				cur_last = (idx_q == WRITE_LAST);
				case (idx_q)
					3'd0: cur_byte = SYNC_BYTE;
					3'd1: cur_byte = {6'd0, job.node};
					3'd2: cur_byte = WRITE_FLAG | {1'b0, job.reg_addr};
					3'd3: cur_byte = job.data[31:24];
					3'd4: cur_byte = job.data[23:16];
					3'd5: cur_byte = job.data[15:8];
					3'd6: cur_byte = job.data[7:0];
					default: cur_byte = crc_q;
				endcase
			end
			JOB_READ: begin
				cur_last = (idx_q == READ_LAST);
				case (idx_q)
					3'd0: cur_byte = SYNC_BYTE;
					3'd1: cur_byte = {6'd0, job.node};
					3'd2: cur_byte = {1'b0, job.reg_addr};
					default: cur_byte = crc_q;
				endcase
			end
			default: begin
				cur_last = 1'b1;
			end
		endcase

		if (job.kind == JOB_REPLY) begin
			next_res.kind = KIND_REPLY;
			next_res.tx_byte = 8'd0;
			next_res.last = 1'b0;
			next_res.reply_data = job.data;
			next_res.reply_register = job.reg_addr;
			next_res.crc_ok = job.crc_ok;
		end else begin
			next_res.kind = KIND_TX;
			next_res.tx_byte = cur_byte;
			next_res.last = cur_last;
			next_res.reply_data = 32'd0;
			next_res.reply_register = 7'd0;
			next_res.crc_ok = 1'b0;
		end
	end

	// Load a new beat whenever the output slot is free or being drained.
	assign load    = job_valid && (!out_valid_q || pop);
	assign job_pop = load && cur_last;
	assign empty   = !out_valid_q;
	assign result  = result_q;

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= next_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			crc_q       <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				if (cur_last) begin
					idx_q <= 3'd0;
					crc_q <= 8'd0;
				end else begin
					idx_q <= idx_q + 3'd1;
					crc_q <= crc8_feed(crc_q, cur_byte);
				end
			end
		end
	end

endmodule

// File: verif/swude_link_mirror_pkg.sv
// Expected-beat tracker for the single-wire UART datagram engine testbench.
// Depends on swude_pkg for the item and result structs and the protocol codes.
package swude_link_mirror_pkg;

	import swude_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	class link_mirror;
		logic [1:0]  node;
		logic [2:0]  echo_left;
		logic [2:0]  gathered;
		logic [55:0] frame;
		logic [7:0]  running_crc;
		result_t     beats_due[$];
		int          faults;
		int          beats_seen;
		int          replies_seen;

		function new();
			node = '0;
			echo_left = '0;
			gathered = '0;
			frame = '0;
			running_crc = '0;
			faults = 0;
			beats_seen = 0;
			replies_seen = 0;
		endfunction

		// CRC-8, polynomial 0x07, data taken least significant bit first.
		static function logic [7:0] crc_step(logic [7:0] acc, logic [7:0] data);
			logic [7:0] a;
			a = acc;
			for (int i = 0; i < 8; i++) begin
				if (a[7] != data[i]) begin
					a = (a << 1) ^ CRC_POLY;
				end else begin
					a = a << 1;
				end
			end
			return a;
		endfunction

		function void add_tx(logic [7:0] b, logic fin);
			result_t r;
			r = '0;
			r.kind = KIND_TX;
			r.tx_byte = b;
			r.last = fin;
			beats_due.push_back(r);
		endfunction

		function void take_item(item_t it);
			logic [7:0] hdr [7];
			logic [7:0] acc;
			result_t    r;
			int         n;
			n = 0;
			case (it.op)
				OP_WRITE: begin
					hdr = '{SYNC_BYTE, {6'd0, node}, WRITE_FLAG | {1'b0, it.reg_addr},
						it.write_data[31:24], it.write_data[23:16],
						it.write_data[15:8], it.write_data[7:0]};
					n = 7;
				end
				OP_READ: begin
					hdr[0] = SYNC_BYTE;
					hdr[1] = {6'd0, node};
					hdr[2] = {1'b0, it.reg_addr};
					n = 3;
					echo_left = ECHO_LEN;
					gathered = '0;
					frame = '0;
					running_crc = '0;
				end
				OP_RX: begin
					if (echo_left != 0) begin
						echo_left = echo_left - 3'd1;
					end else if (gathered != REPLY_LAST) begin
						frame = {frame[47:0], it.rx_byte};
						running_crc = crc_step(running_crc, it.rx_byte);
						gathered = gathered + 3'd1;
					end else begin
						r = '0;
						r.kind = KIND_REPLY;
						r.reply_data = frame[31:0];
						r.reply_register = frame[38:32];
						r.crc_ok = (running_crc == it.rx_byte);
						beats_due.push_back(r);
						gathered = '0;
						frame = '0;
						running_crc = '0;
					end
				end
				default: ;
			endcase
			if (n > 0) begin
				acc = '0;
				for (int i = 0; i < n; i++) begin
					acc = crc_step(acc, hdr[i]);
					add_tx(hdr[i], 1'b0);
				end
				add_tx(acc, 1'b1);
			end
		endfunction

		function void flag(string field, logic [31:0] want, logic [31:0] got);
			faults++;
			$error("%s: expected %0h, got %0h", field, want, got);
		endfunction

		function void match_beat(result_t got);
			result_t want;
			if (beats_due.size() == 0) begin
				faults++;
				$error("result beat with nothing outstanding: %0h", got);
				return;
			end
			want = beats_due.pop_front();
			beats_seen++;
			if (want.kind == KIND_REPLY) begin
				replies_seen++;
			end
			if (got.kind !== want.kind) flag("kind", want.kind, got.kind);
			if (got.tx_byte !== want.tx_byte) flag("tx_byte", want.tx_byte, got.tx_byte);
			if (got.last !== want.last) flag("last", want.last, got.last);
			if (got.reply_data !== want.reply_data)
				flag("reply_data", want.reply_data, got.reply_data);
			if (got.reply_register !== want.reply_register)
				flag("reply_register", want.reply_register, got.reply_register);
			if (got.crc_ok !== want.crc_ok) flag("crc_ok", want.crc_ok, got.crc_ok);
		endfunction

		function int pending();
			return beats_due.size();
		endfunction
	endclass

endpackage

// File: verif/single_wire_uart_datagram_engine_core_tb.sv
// Self-checking testbench for single_wire_uart_datagram_engine_core.
// Depends on swude_pkg and swude_link_mirror_pkg; drives both queue-style ports.
module single_wire_uart_datagram_engine_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import swude_pkg::*;
	import swude_link_mirror_pkg::*;

	// Cycles to hold after the last expected beat: covers bytes still in the
	// front end that produce no beat.
	localparam int SETTLE = 16;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_data = '0;
	logic       push = 1'b0;
	item_t      item = '0;
	logic       pop = 1'b0;
	logic       full;
	logic       empty;
	result_t    result;

	link_mirror mirror;
	bit         calm;          // no idling on either side while set
	int         pushed;        // accepted items that the block acts on
	int         node_settings;

	single_wire_uart_datagram_engine_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.push     (push),
		.full     (full),
		.item     (item),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly back-to-back, some short gaps, a few long ones.
	function automatic int gap_len();
		int roll;
		if (calm) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	function automatic item_t make_item(logic [1:0] op, logic [6:0] ra, logic [31:0] wd,
			logic [7:0] rb);
		item_t it;
		it.op = op;
		it.reg_addr = ra;
		it.write_data = wd;
		it.rx_byte = rb;
		return it;
	endfunction

	// Offer one beat and hold it until the block takes it. Push is either
	// lowered for a gap or left high for the next beat, never both in one step.
	task automatic send(item_t it);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full) @(posedge clk);
		mirror.take_item(it);
		if (it.op != OP_UNUSED) pushed++;
	endtask

	task automatic feed_byte(logic [7:0] b);
		send(make_item(OP_RX, 7'($urandom), $urandom, b));
	endtask

	task automatic request_write(logic [6:0] ra, logic [31:0] wd);
		send(make_item(OP_WRITE, ra, wd, 8'($urandom)));
	endtask

	task automatic request_read(logic [6:0] ra);
		send(make_item(OP_READ, ra, $urandom, 8'($urandom)));
	endtask

	task automatic ignored_op();
		send(make_item(OP_UNUSED, 7'($urandom), $urandom, 8'($urandom)));
	endtask

	// Read request, its four echoed bytes and an eight-byte reply. The CRC is
	// usually right; now and then one bit of it is flipped. A write request is
	// sometimes slipped in at a random point of the exchange.
	task automatic read_transaction();
		logic [7:0] seq [12];
		logic [7:0] crc;
		int         cut;
		int         fill;
		for (int i = 0; i < 12; i++) seq[i] = 8'($urandom);
		seq[4] = ($urandom_range(0, 3) != 0) ? SYNC_BYTE : 8'($urandom);
		if ($urandom_range(0, 3) != 0) seq[5] = {6'd0, 2'($urandom)};
		fill = $urandom_range(0, 15);
		if (fill < 2) begin
			for (int i = 7; i < 11; i++) seq[i] = (fill == 0) ? 8'h00 : 8'hFF;
		end
		crc = '0;
		for (int i = 4; i < 11; i++) crc = link_mirror::crc_step(crc, seq[i]);
		if ($urandom_range(0, 4) == 0) crc = crc ^ (8'd1 << $urandom_range(0, 7));
		seq[11] = crc;
		request_read(7'($urandom));
		cut = $urandom_range(0, 40);
		for (int i = 0; i < 12; i++) begin
			if (i == cut) request_write(7'($urandom), $urandom);
			feed_byte(seq[i]);
		end
	endtask

	task automatic random_traffic(int goal);
		int roll;
		int n;
		while (pushed < goal) begin
			roll = $urandom_range(0, 99);
			if (roll < 25) begin
				case ($urandom_range(0, 7))
					0: request_write(7'd0, 32'h0000_0000);
					1: request_write(7'd127, 32'hFFFF_FFFF);
					default: request_write(7'($urandom), $urandom);
				endcase
			end else if (roll < 70) begin
				read_transaction();
			end else if (roll < 80) begin
				n = $urandom_range(1, 6);
				repeat (n) feed_byte(8'($urandom));
			end else if (roll < 85) begin
				ignored_op();
			end else if (roll < 92) begin
				// Read cut short inside the echo window.
				request_read(7'($urandom));
				n = $urandom_range(0, 3);
				repeat (n) feed_byte(8'($urandom));
			end else begin
				// Reply cut short; the next read must clear what was gathered.
				request_read(7'($urandom));
				n = $urandom_range(5, 11);
				repeat (n) feed_byte(8'($urandom));
			end
		end
	endtask

	// Drop push, wait for every expected beat, then let the front end settle.
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (mirror.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_node(logic [1:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		mirror.node = v;
		node_settings++;
	endtask

	// Extremes of every field, the ignored op, a read restarted inside its
	// echo window, and a reply whose CRC is wrong.
	task automatic directed();
		logic [7:0] body [7];
		logic [7:0] crc;
		request_write(7'd0, 32'h0000_0000);
		request_write(7'd127, 32'hFFFF_FFFF);
		ignored_op();
		request_read(7'd127);
		feed_byte(8'h00);
		feed_byte(8'hFF);
		request_read(7'd0);
		repeat (4) feed_byte(8'($urandom));
		body = '{SYNC_BYTE, 8'h00, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h01};
		crc = '0;
		foreach (body[i]) begin
			crc = link_mirror::crc_step(crc, body[i]);
			feed_byte(body[i]);
		end
		feed_byte(crc ^ 8'h01);
		// Gather with no read in front of it.
		feed_byte(8'hFF);
	endtask

	// Result side: pop with random stalls, check each beat taken.
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = gap_len();
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			mirror.match_beat(result);
		end
	end

	initial begin
		logic [1:0] nodes [4];
		mirror = new();
		calm = 1'b0;
		pushed = 0;
		node_settings = 0;
		nodes = '{2'd3, 2'd1, 2'd2, 2'd0};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Node address still at its reset value for the first phase.
		directed();
		random_traffic(pushed + 30);
		drain();

		foreach (nodes[i]) begin
			calm = (i == 1);
			set_node(nodes[i]);
			random_traffic(pushed + 40);
			drain();
		end

		$display("%0d items accepted, %0d result beats checked including %0d replies",
			pushed, mirror.beats_seen, mirror.replies_seen);
		$display("%0d node address settings, idle gaps on both ports and one gap-free phase",
			node_settings);
		if (mirror.faults == 0) begin
			$display("single_wire_uart_datagram_engine_core_tb: clean");
		end else begin
			$display("single_wire_uart_datagram_engine_core_tb: errors");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#3_000_000;
		$display("single_wire_uart_datagram_engine_core_tb: errors");
		$finish;
	end

endmodule

// File: single_wire_uart_datagram_engine_core.f
src/swude_pkg.sv
src/swude_front.sv
src/swude_queue.sv
src/swude_back.sv
src/single_wire_uart_datagram_engine_core.sv
verif/swude_link_mirror_pkg.sv
verif/single_wire_uart_datagram_engine_core_tb.sv
